[hdl/vbcc_pkg.sv]
// shared types, constants and helper functions of the verlet ball block
package vbcc_pkg;

  localparam int MAX_CIRCLES_DEF = 16;
  localparam int IN_W  = 80;
  localparam int USR_W = 2;
  localparam int OUT_W = 136;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int TAB_W = 64;
  localparam int WIDE_W = 54;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_COUNT = 2'd2,
    ACT_PLACE = 2'd3
  } action_e;

  localparam logic [CFG_AW-1:0] CFG_GRAVITY  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_FRICTION = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_BOUNCE   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MINSPEED = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_WIDTH    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT   = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_RADIUS   = 3'd6;

  localparam logic [15:0] GRAVITY_RST  = 16'd128;
  localparam logic [15:0] FRICTION_RST = 16'd64880;
  localparam logic [15:0] BOUNCE_RST   = 16'd32768;
  localparam logic [15:0] MINSPEED_RST = 16'd26;
  localparam logic [12:0] WIDTH_RST    = 13'd1920;
  localparam logic [12:0] HEIGHT_RST   = 13'd1080;
  localparam logic [15:0] RADIUS_RST   = 16'd7680;
  localparam logic signed [23:0] POS_RST = 24'sd76800;

  function automatic logic signed [23:0] sat24(input logic signed [WIDE_W-1:0] v);
    logic signed [23:0] r;
    if (v > $signed(WIDE_W'(24'sh7fffff))) begin
      r = 24'sh7fffff;
    end else if (v < -$signed(WIDE_W'(8388608))) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // product scaled by 2^-16, truncated toward zero
  function automatic logic signed [35:0] q16(input logic signed [51:0] p);
    logic signed [51:0] t;
    t = p[51] ? p + 52'sd65535 : p;
    return t[51:16];
  endfunction

  // (pos - radius) / 256 toward zero, saturated to 16 bits
  function automatic logic [15:0] win16(input logic signed [23:0] pos,
                                        input logic [15:0] rad);
    logic signed [24:0] v;
    logic signed [24:0] t;
    logic signed [16:0] w;
    logic [15:0] r;
    v = 25'(pos) - $signed({9'b0, rad});
    t = v[24] ? v + 25'sd255 : v;
    w = t[24:8];
    if (w > 17'sd32767) begin
      r = 16'h7fff;
    end else if (w < -17'sd32768) begin
      r = 16'h8000;
    end else begin
      r = w[15:0];
    end
    return r;
  endfunction

endpackage

[hdl/vbcc_ram.sv]
// generic single write port ram with registered read
module vbcc_ram #(
  parameter int W = 8,
  parameter int D = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[hdl/verlet_ball_with_circle_collisions.sv]
// verlet ball with obstacle circle collisions, top level
// A tick runs the press test when pressed, then motion and walls unless
// dragging, then checks each valid circle in turn; one that overlaps
// also needs a 26-step square root and two 44-step dividers in sequence.
// The circle table sits in one ram read one slot per cycle. The result
// waits in an output register; a new beat is taken once it is consumed.
module verlet_ball_with_circle_collisions #(
  parameter int MAX_CIRCLES = vbcc_pkg::MAX_CIRCLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // circle_index, pos_x, pos_y, circle_radius, circle_count, pressed, released
  input  logic [vbcc_pkg::IN_W-1:0]   s_axis_tdata,
  // action
  input  logic [vbcc_pkg::USR_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // ball_x, ball_y, prev_x, prev_y, window_x, window_y, is_dragging
  output logic [vbcc_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [vbcc_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [vbcc_pkg::CFG_DW-1:0] cfg_data_i
);
  import vbcc_pkg::*;

  localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW = $clog2(MAX_CIRCLES + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_P0   = 5'd1;
  localparam logic [4:0] S_P1   = 5'd2;
  localparam logic [4:0] S_P2   = 5'd3;
  localparam logic [4:0] S_P3   = 5'd4;
  localparam logic [4:0] S_DRAG = 5'd5;
  localparam logic [4:0] S_F0   = 5'd6;
  localparam logic [4:0] S_F1   = 5'd7;
  localparam logic [4:0] S_F2   = 5'd8;
  localparam logic [4:0] S_F3   = 5'd9;
  localparam logic [4:0] S_F4   = 5'd10;
  localparam logic [4:0] S_F5   = 5'd11;
  localparam logic [4:0] S_F6   = 5'd12;
  localparam logic [4:0] S_F7   = 5'd13;
  localparam logic [4:0] S_F8   = 5'd14;
  localparam logic [4:0] S_F9   = 5'd15;
  localparam logic [4:0] S_C0   = 5'd16;
  localparam logic [4:0] S_C1   = 5'd17;
  localparam logic [4:0] S_C2   = 5'd18;
  localparam logic [4:0] S_C3   = 5'd19;
  localparam logic [4:0] S_C4   = 5'd20;
  localparam logic [4:0] S_C5   = 5'd21;
  localparam logic [4:0] S_C6   = 5'd22;
  localparam logic [4:0] S_C7   = 5'd23;
  localparam logic [4:0] S_SQ   = 5'd24;
  localparam logic [4:0] S_DIV  = 5'd25;
  localparam logic [4:0] S_DQ   = 5'd26;
  localparam logic [4:0] S_OUT  = 5'd27;

  logic [4:0] state_q;
  logic       out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic [15:0] grav_q, fric_q, bnc_q, mspd_q, rad_q;
  logic [12:0] scr_w_q, scr_h_q;

  logic signed [23:0] cur_x_q, cur_y_q, old_x_q, old_y_q, off_x_q, off_y_q;
  logic               drag_q;
  logic [CW-1:0]      count_q, idx_q;

  logic signed [23:0] px_q, py_q;
  logic               rel_q;

  logic signed [25:0] op_a_q, op_b_q;
  logic signed [51:0] prod;
  logic signed [35:0] prod_scl;
  logic signed [52:0] acc_q;

  logic signed [24:0] vx_q, vy_q, bvx_q, bvy_q, dx_q, dy_q;
  logic signed [27:0] nx_q, ny_q, ox_q, oy_q;
  logic [16:0]        m_q, s_q;
  logic [51:0]        sq_rem_q, sq_root_q, sq_bit_q;
  logic signed [43:0] numy_q;
  logic [43:0]        dv_num_q;
  logic [27:0]        dv_rem_q, dv_den_q;
  logic [5:0]         dv_cnt_q;
  logic               dv_neg_q, dv_axis_q;
  logic signed [43:0] qx_q;

  logic               in_beat;
  action_e            act;
  logic [TAB_W-1:0]   tab_rd;
  logic               tab_we;
  logic [AW-1:0]      tab_waddr;

  logic signed [24:0] c_dx, c_dy, p_dx, p_dy;
  logic signed [17:0] msub;
  logic [51:0]        sq_try;
  logic [27:0]        dv_t;
  logic               dv_ge;
  logic signed [43:0] dv_q;
  logic signed [24:0] vxs, vys;
  logic               slow;
  logic signed [27:0] rr, hh, ww, wx, wxo, wy, wyo;
  logic signed [43:0] numx_abs, numy_abs;

  assign prod = op_a_q * op_b_q;
  assign prod_scl = q16(prod);
  assign act = action_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  assign tab_we = in_beat && (act == ACT_LOAD) && (int'(s_axis_tdata[3:0]) < MAX_CIRCLES);
  assign tab_waddr = AW'(s_axis_tdata[3:0]);

  vbcc_ram #(
    .W(TAB_W),
    .D(MAX_CIRCLES),
    .AW(AW)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i ({s_axis_tdata[67:52], s_axis_tdata[51:28], s_axis_tdata[27:4]}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (tab_rd)
  );

  always_comb begin
    p_dx = 25'(px_q) - 25'(cur_x_q);
    p_dy = 25'(py_q) - 25'(cur_y_q);
    c_dx = 25'(cur_x_q) - 25'($signed(tab_rd[23:0]));
    c_dy = 25'(cur_y_q) - 25'($signed(tab_rd[47:24]));
    msub = $signed({1'b0, m_q}) - $signed({1'b0, s_q});
    sq_try = sq_root_q + sq_bit_q;
    dv_t = {dv_rem_q[26:0], dv_num_q[43]};
    dv_ge = dv_t >= dv_den_q;
    dv_q = dv_neg_q ? -$signed(dv_num_q) : $signed(dv_num_q);
    slow = acc_q < 53'(prod);
    vxs = slow ? '0 : vx_q;
    vys = slow ? '0 : vy_q;
    numx_abs = prod[43] ? -prod[43:0] : prod[43:0];
    numy_abs = numy_q[43] ? -numy_q : numy_q;
    rr = $signed({12'b0, rad_q});
    hh = $signed({7'b0, scr_h_q, 8'b0});
    ww = $signed({7'b0, scr_w_q, 8'b0});
    wy = ny_q;
    wyo = oy_q;
    if (wy + rr > hh) begin
      wy = hh - rr;
      wyo = wy - 28'(bvy_q);
    end
    if (wy - rr < 28'sd0) begin
      wy = rr;
      wyo = wy - 28'(bvy_q);
    end
    wx = nx_q;
    wxo = ox_q;
    if (wx + rr > ww) begin
      wx = ww - rr;
      wxo = wx - 28'(bvx_q);
    end
    if (wx - rr < 28'sd0) begin
      wx = rr;
      wxo = wx - 28'(bvx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      out_data_q <= '0;
      grav_q <= GRAVITY_RST;
      fric_q <= FRICTION_RST;
      bnc_q <= BOUNCE_RST;
      mspd_q <= MINSPEED_RST;
      scr_w_q <= WIDTH_RST;
      scr_h_q <= HEIGHT_RST;
      rad_q <= RADIUS_RST;
      cur_x_q <= POS_RST;
      cur_y_q <= POS_RST;
      old_x_q <= POS_RST;
      old_y_q <= POS_RST;
      off_x_q <= '0;
      off_y_q <= '0;
      drag_q <= 1'b0;
      count_q <= '0;
      idx_q <= '0;
      px_q <= '0;
      py_q <= '0;
      rel_q <= 1'b0;
      op_a_q <= '0;
      op_b_q <= '0;
      acc_q <= '0;
      vx_q <= '0;
      vy_q <= '0;
      bvx_q <= '0;
      bvy_q <= '0;
      dx_q <= '0;
      dy_q <= '0;
      nx_q <= '0;
      ny_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      m_q <= '0;
      s_q <= '0;
      sq_rem_q <= '0;
      sq_root_q <= '0;
      sq_bit_q <= '0;
      numy_q <= '0;
      dv_num_q <= '0;
      dv_rem_q <= '0;
      dv_den_q <= '0;
      dv_cnt_q <= '0;
      dv_neg_q <= 1'b0;
      dv_axis_q <= 1'b0;
      qx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRAVITY:  grav_q <= cfg_data_i;
          CFG_FRICTION: fric_q <= cfg_data_i;
          CFG_BOUNCE:   bnc_q <= cfg_data_i;
          CFG_MINSPEED: mspd_q <= cfg_data_i;
          CFG_WIDTH:    scr_w_q <= cfg_data_i[12:0];
          CFG_HEIGHT:   scr_h_q <= cfg_data_i[12:0];
          CFG_RADIUS:   rad_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            case (act)
              ACT_COUNT: begin
                if (int'(s_axis_tdata[72:68]) > MAX_CIRCLES) begin
                  count_q <= CW'(MAX_CIRCLES);
                end else begin
                  count_q <= CW'(s_axis_tdata[72:68]);
                end
              end
              ACT_PLACE: begin
                cur_x_q <= $signed(s_axis_tdata[27:4]);
                old_x_q <= $signed(s_axis_tdata[27:4]);
                cur_y_q <= $signed(s_axis_tdata[51:28]);
                old_y_q <= $signed(s_axis_tdata[51:28]);
              end
              ACT_TICK: begin
                px_q <= $signed(s_axis_tdata[27:4]);
                py_q <= $signed(s_axis_tdata[51:28]);
                rel_q <= s_axis_tdata[74];
                idx_q <= '0;
                state_q <= s_axis_tdata[73] ? S_P0 : S_DRAG;
              end
              default: ;
            endcase
          end
        end
        S_P0: begin
          op_a_q <= 26'(p_dx);
          op_b_q <= 26'(p_dx);
          state_q <= S_P1;
        end
        S_P1: begin
          acc_q <= 53'(prod);
          op_a_q <= 26'(p_dy);
          op_b_q <= 26'(p_dy);
          state_q <= S_P2;
        end
        S_P2: begin
          acc_q <= acc_q + 53'(prod);
          op_a_q <= $signed({10'b0, rad_q});
          op_b_q <= $signed({10'b0, rad_q});
          state_q <= S_P3;
        end
        S_P3: begin
          if (acc_q <= 53'(prod)) begin
            drag_q <= 1'b1;
            off_x_q <= sat24(WIDE_W'(cur_x_q) - WIDE_W'(px_q));
            off_y_q <= sat24(WIDE_W'(cur_y_q) - WIDE_W'(py_q));
          end
          state_q <= S_DRAG;
        end
        S_DRAG: begin
          if (rel_q) begin
            drag_q <= 1'b0;
            state_q <= S_F0;
          end else if (drag_q) begin
            old_x_q <= cur_x_q;
            old_y_q <= cur_y_q;
            cur_x_q <= sat24(WIDE_W'(px_q) + WIDE_W'(off_x_q));
            cur_y_q <= sat24(WIDE_W'(py_q) + WIDE_W'(off_y_q));
            state_q <= S_C0;
          end else begin
            state_q <= S_F0;
          end
        end
        S_F0: begin
          op_a_q <= 26'(25'(cur_x_q) - 25'(old_x_q));
          op_b_q <= $signed({10'b0, fric_q});
          state_q <= S_F1;
        end
        S_F1: begin
          vx_q <= prod_scl[24:0];
          op_a_q <= 26'(25'(cur_y_q) - 25'(old_y_q));
          state_q <= S_F2;
        end
        S_F2: begin
          vy_q <= prod_scl[24:0];
          op_a_q <= 26'(vx_q);
          op_b_q <= 26'(vx_q);
          state_q <= S_F3;
        end
        S_F3: begin
          acc_q <= 53'(prod);
          op_a_q <= 26'(vy_q);
          op_b_q <= 26'(vy_q);
          state_q <= S_F4;
        end
        S_F4: begin
          acc_q <= acc_q + 53'(prod);
          op_a_q <= $signed({10'b0, mspd_q});
          op_b_q <= $signed({10'b0, mspd_q});
          state_q <= S_F5;
        end
        S_F5: begin
          vx_q <= vxs;
          vy_q <= vys;
          ox_q <= 28'(cur_x_q);
          oy_q <= 28'(cur_y_q);
          nx_q <= 28'(cur_x_q) + 28'(vxs);
          ny_q <= 28'(cur_y_q) + 28'(vys) + $signed({12'b0, grav_q});
          state_q <= S_F6;
        end
        S_F6: begin
          op_a_q <= 26'(vy_q);
          op_b_q <= $signed({10'b0, bnc_q});
          state_q <= S_F7;
        end
        S_F7: begin
          bvy_q <= prod_scl[24:0];
          op_a_q <= 26'(vx_q);
          state_q <= S_F8;
        end
        S_F8: begin
          bvx_q <= prod_scl[24:0];
          state_q <= S_F9;
        end
        S_F9: begin
          cur_x_q <= sat24(WIDE_W'(wx));
          cur_y_q <= sat24(WIDE_W'(wy));
          old_x_q <= sat24(WIDE_W'(wxo));
          old_y_q <= sat24(WIDE_W'(wyo));
          state_q <= S_C0;
        end
        S_C0: begin
          state_q <= (idx_q < count_q) ? S_C1 : S_OUT;
        end
        S_C1: begin
          dx_q <= c_dx;
          dy_q <= c_dy;
          m_q <= 17'(rad_q) + 17'(tab_rd[63:48]);
          op_a_q <= 26'(c_dx);
          op_b_q <= 26'(c_dx);
          state_q <= S_C2;
        end
        S_C2: begin
          acc_q <= 53'(prod);
          op_a_q <= 26'(dy_q);
          op_b_q <= 26'(dy_q);
          state_q <= S_C3;
        end
        S_C3: begin
          acc_q <= acc_q + 53'(prod);
          op_a_q <= $signed({9'b0, m_q});
          op_b_q <= $signed({9'b0, m_q});
          state_q <= S_C4;
        end
        S_C4: begin
          if (acc_q >= 53'(prod) || acc_q == '0) begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_C0;
          end else begin
            sq_rem_q <= acc_q[51:0];
            sq_root_q <= '0;
            sq_bit_q <= 52'd1 << 50;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_rem_q >= sq_try) begin
            sq_rem_q <= sq_rem_q - sq_try;
            sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
          end else begin
            sq_root_q <= sq_root_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            state_q <= S_C5;
          end
        end
        S_C5: begin
          s_q <= sq_root_q[16:0];
          state_q <= S_C6;
        end
        S_C6: begin
          op_a_q <= 26'(dx_q);
          op_b_q <= 26'(msub);
          state_q <= S_C7;
        end
        S_C7: begin
          // x numerator now on the multiplier, y issued next
          op_a_q <= 26'(dy_q);
          dv_neg_q <= prod[43];
          dv_num_q <= numx_abs;
          dv_rem_q <= '0;
          dv_den_q <= {10'b0, s_q, 1'b0};
          dv_cnt_q <= '0;
          dv_axis_q <= 1'b0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dv_cnt_q == 6'd0 && !dv_axis_q) begin
            numy_q <= prod[43:0];
          end
          dv_rem_q <= dv_ge ? dv_t - dv_den_q : dv_t;
          dv_num_q <= {dv_num_q[42:0], dv_ge};
          dv_cnt_q <= dv_cnt_q + 6'd1;
          if (dv_cnt_q == 6'd43) begin
            state_q <= S_DQ;
          end
        end
        S_DQ: begin
          if (!dv_axis_q) begin
            qx_q <= dv_q;
            dv_neg_q <= numy_q[43];
            dv_num_q <= numy_abs;
            dv_rem_q <= '0;
            dv_cnt_q <= '0;
            dv_axis_q <= 1'b1;
            state_q <= S_DIV;
          end else begin
            cur_x_q <= sat24(WIDE_W'(cur_x_q) + WIDE_W'(qx_q));
            cur_y_q <= sat24(WIDE_W'(cur_y_q) + WIDE_W'(dv_q));
            idx_q <= idx_q + 1'b1;
            state_q <= S_C0;
          end
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          out_data_q <= {7'b0, drag_q, win16(cur_y_q, rad_q), win16(cur_x_q, rad_q),
                         old_y_q, old_x_q, cur_y_q, cur_x_q};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/vbcc_checker.sv]
// port level checks of the verlet ball block, bound to the top level
module vbcc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [vbcc_pkg::IN_W-1:0]   s_axis_tdata,
  input logic [vbcc_pkg::USR_W-1:0]  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [vbcc_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                        cfg_we_i,
  input logic [vbcc_pkg::CFG_AW-1:0] cfg_idx_i,
  input logic [vbcc_pkg::CFG_DW-1:0] cfg_data_i
);
  import vbcc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid && !m_axis_tready))
    else $error("input taken while result stalled");

  a_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without work");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1:129] == '0)
    else $error("result padding not zero");
endmodule

bind verlet_ball_with_circle_collisions vbcc_checker u_vbcc_checker (.*);

[verif/testbench.sv]
// self-checking testbench for the verlet ball block with obstacle circle collisions
`timescale 1ns / 100ps

module testbench;
  import vbcc_pkg::*;

  typedef struct {
    action_e           act;
    logic [3:0]        idx;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]       rad;
    logic [4:0]        cnt;
    logic              pr;
    logic              rl;
  } ball_cmd_t;

  typedef struct {
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [23:0] ox;
    logic signed [23:0] oy;
    logic [15:0]        wx;
    logic [15:0]        wy;
    logic               drag;
  } ball_res_t;

  typedef struct {
    ball_cmd_t cmd;
    bit        typed;
    ball_res_t res;
  } dir_row_t;

  logic                clk_i, rst_ni;
  logic                s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;  // circle_index, pos_x, pos_y, circle_radius, circle_count, pressed, released
  logic [USR_W-1:0]    s_axis_tuser;  // action
  logic                m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;  // ball_x, ball_y, prev_x, prev_y, window_x, window_y, is_dragging
  logic                cfg_we_i;
  logic [CFG_AW-1:0]   cfg_idx_i;
  logic [CFG_DW-1:0]   cfg_data_i;

  verlet_ball_with_circle_collisions dut (.*);

  // predictor state
  longint cur_x, cur_y, old_x, old_y, off_x, off_y;
  bit     dragging;
  longint tab_x[16], tab_y[16], tab_r[16];
  int     n_circles;
  longint gravity, friction, bounce, min_spd, scr_w, scr_h, radius;

  ball_res_t pending_balls[$];
  int  mismatches = 0;
  int  n_ticks = 0, n_other = 0, n_drag = 0, n_hits = 0, n_results = 0;
  int  src_idle = 0, dst_idle = 0;
  bit  stall_req = 0;
  int  hold_left = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint sat24(longint v);
    return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
  endfunction

  function automatic longint scale_q16(longint a, longint g);
    if (a < 0) return -(((-a) * g) >> 16);
    return (a * g) >> 16;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint win16(longint p);
    longint w;
    w = (p - radius) / 256;
    return w > 32767 ? 32767 : (w < -32768 ? -32768 : w);
  endfunction

  // returns 1 and the new ball state for a tick
  function automatic bit advance_ball(ball_cmd_t c, output ball_res_t res);
    longint px, py, dx, dy, vx, vy, nx, ny, ox, oy, d2, m, s;
    px = c.px;
    py = c.py;
    case (c.act)
      ACT_LOAD: begin
        tab_x[c.idx] = px;
        tab_y[c.idx] = py;
        tab_r[c.idx] = c.rad;
        return 0;
      end
      ACT_COUNT: begin
        n_circles = c.cnt > 16 ? 16 : c.cnt;
        return 0;
      end
      ACT_PLACE: begin
        cur_x = px; old_x = px;
        cur_y = py; old_y = py;
        return 0;
      end
      default: ;
    endcase
    if (c.pr) begin
      dx = px - cur_x;
      dy = py - cur_y;
      if (dx * dx + dy * dy <= radius * radius) begin
        dragging = 1;
        off_x = sat24(cur_x - px);
        off_y = sat24(cur_y - py);
      end
    end
    if (c.rl) dragging = 0;
    if (dragging) begin
      n_drag++;
      old_x = cur_x;
      old_y = cur_y;
      cur_x = sat24(px + off_x);
      cur_y = sat24(py + off_y);
    end else begin
      vx = scale_q16(cur_x - old_x, friction);
      vy = scale_q16(cur_y - old_y, friction);
      if (vx * vx + vy * vy < min_spd * min_spd) begin
        vx = 0;
        vy = 0;
      end
      ox = cur_x;
      oy = cur_y;
      nx = cur_x + vx;
      ny = cur_y + vy + gravity;
      if (ny + radius > scr_h * 256) begin
        ny = scr_h * 256 - radius;
        oy = ny - scale_q16(vy, bounce);
      end
      if (ny - radius < 0) begin
        ny = radius;
        oy = ny - scale_q16(vy, bounce);
      end
      if (nx + radius > scr_w * 256) begin
        nx = scr_w * 256 - radius;
        ox = nx - scale_q16(vx, bounce);
      end
      if (nx - radius < 0) begin
        nx = radius;
        ox = nx - scale_q16(vx, bounce);
      end
      cur_x = sat24(nx);
      cur_y = sat24(ny);
      old_x = sat24(ox);
      old_y = sat24(oy);
    end
    for (int i = 0; i < n_circles; i++) begin
      dx = cur_x - tab_x[i];
      dy = cur_y - tab_y[i];
      d2 = dx * dx + dy * dy;
      m = radius + tab_r[i];
      if (d2 >= m * m || d2 == 0) continue;
      n_hits++;
      s = int_sqrt(d2);
      cur_x = sat24(cur_x + (dx * (m - s)) / (2 * s));
      cur_y = sat24(cur_y + (dy * (m - s)) / (2 * s));
    end
    res.bx = 24'(cur_x);
    res.by = 24'(cur_y);
    res.ox = 24'(old_x);
    res.oy = 24'(old_y);
    res.wx = 16'(win16(cur_x));
    res.wy = 16'(win16(cur_y));
    res.drag = dragging;
    return 1;
  endfunction

  function automatic ball_cmd_t mk(action_e a, int idx, longint px, longint py,
                                   int rad, int cnt, bit pr, bit rl);
    ball_cmd_t c;
    c.act = a; c.idx = 4'(idx); c.px = 24'(px); c.py = 24'(py);
    c.rad = 16'(rad); c.cnt = 5'(cnt); c.pr = pr; c.rl = rl;
    return c;
  endfunction

  function automatic ball_res_t mk_res(longint bx, longint by, longint ox, longint oy,
                                       int wx, int wy, bit drag);
    ball_res_t r;
    r.bx = 24'(bx); r.by = 24'(by); r.ox = 24'(ox); r.oy = 24'(oy);
    r.wx = 16'(wx); r.wy = 16'(wy); r.drag = drag;
    return r;
  endfunction

  function automatic longint near(longint c, int span_px);
    return sat24(c + longint'($urandom_range(0, 2 * span_px * 256)) - span_px * 256);
  endfunction

  function automatic longint any_pos();
    return longint'($signed(24'($urandom)));
  endfunction

  function automatic ball_cmd_t random_cmd();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      if ($urandom_range(0, 3) == 0)
        return mk(ACT_TICK, $urandom, near(cur_x, 40), near(cur_y, 40), $urandom, $urandom,
                  1, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0)
        return mk(ACT_TICK, $urandom, any_pos(), any_pos(), $urandom, $urandom,
                  $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      return mk(ACT_TICK, $urandom, near(cur_x, 300), near(cur_y, 300), $urandom, $urandom,
                $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    end
    if (k < 75) begin
      if ($urandom_range(0, 9) == 0)
        return mk(ACT_LOAD, $urandom, any_pos(), any_pos(), $urandom, $urandom, 0, 0);
      return mk(ACT_LOAD, $urandom, near(cur_x, 80), near(cur_y, 80),
                $urandom_range(0, 40 * 256), $urandom,
                $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
    end
    if (k < 85)
      return mk(ACT_COUNT, $urandom, any_pos(), any_pos(), $urandom, $urandom_range(0, 31),
                $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
    if ($urandom_range(0, 9) == 0)
      return mk(ACT_PLACE, $urandom, any_pos(), any_pos(), $urandom, $urandom, 0, 0);
    return mk(ACT_PLACE, $urandom, $urandom_range(0, 2000 * 256), $urandom_range(0, 1100 * 256),
              $urandom, $urandom, $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
  endfunction

  // drive one beat from a falling edge, leaves at the falling edge after acceptance
  task automatic send_beat(ball_cmd_t c, bit typed, ball_res_t typed_res);
    ball_res_t r;
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.act;
    s_axis_tdata  <= {5'b0, c.rl, c.pr, c.cnt, c.rad, c.py, c.px, c.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (advance_ball(c, r)) begin
      n_ticks++;
      pending_balls.push_back(typed ? typed_res : r);
    end else begin
      n_other++;
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 16'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GRAVITY:  gravity  = val & 16'hffff;
      CFG_FRICTION: friction = val & 16'hffff;
      CFG_BOUNCE:   bounce   = val & 16'hffff;
      CFG_MINSPEED: min_spd  = val & 16'hffff;
      CFG_WIDTH:    scr_w    = val & 13'h1fff;
      CFG_HEIGHT:   scr_h    = val & 13'h1fff;
      CFG_RADIUS:   radius   = val & 16'hffff;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_balls.size() != 0) @(negedge clk_i);
    repeat (2200) @(negedge clk_i);
  endtask

  // output checker
  always @(posedge clk_i) begin
    ball_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.bx = m_axis_tdata[23:0];
      got.by = m_axis_tdata[47:24];
      got.ox = m_axis_tdata[71:48];
      got.oy = m_axis_tdata[95:72];
      got.wx = m_axis_tdata[111:96];
      got.wy = m_axis_tdata[127:112];
      got.drag = m_axis_tdata[128];
      n_results++;
      if (pending_balls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_balls.pop_front();
        if (got.bx !== want.bx || got.by !== want.by || got.ox !== want.ox ||
            got.oy !== want.oy || got.wx !== want.wx || got.wy !== want.wy ||
            got.drag !== want.drag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp ball %0d,%0d prev %0d,%0d win %0d,%0d drag %0b",
                     $realtime, want.bx, want.by, want.ox, want.oy,
                     $signed(want.wx), $signed(want.wy), want.drag,
                     "\n  got ball %0d,%0d prev %0d,%0d win %0d,%0d drag %0b",
                     got.bx, got.by, got.ox, got.oy,
                     $signed(got.wx), $signed(got.wy), got.drag);
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= dst_idle;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    ball_res_t none;
    int src_tab[4] = '{21, 64, 0, 21};
    int dst_tab[4] = '{64, 21, 0, 64};

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_TICK;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_GRAVITY;
    cfg_data_i = '0;
    none = mk_res(0, 0, 0, 0, 0, 0, 0);

    cur_x = 76800; cur_y = 76800; old_x = 76800; old_y = 76800;
    off_x = 0; off_y = 0; dragging = 0; n_circles = 0;
    gravity = 128; friction = 64880; bounce = 32768; min_spd = 26;
    scr_w = 1920; scr_h = 1080; radius = 7680;
    foreach (tab_x[i]) begin
      tab_x[i] = 0; tab_y[i] = 0; tab_r[i] = 0;
    end

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    row.typed = 1;
    row.cmd = mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0);
    row.res = mk_res(76800, 76928, 76800, 76800, 270, 270, 0);
    rows.push_back(row);
    row.typed = 0;
    row.res = none;
    row.cmd = mk(ACT_LOAD, 0, 400 * 256, 300 * 256, 80 * 256, 0, 0, 0);
    rows.push_back(row);
    for (int i = 1; i < 14; i++) begin
      row.cmd = mk(ACT_LOAD, i, (100 + i * 130) * 256, 1000 * 256, i * 3 * 256, 0, 0, 0);
      rows.push_back(row);
    end
    row.cmd = mk(ACT_LOAD, 14, 8388607, -8388608, 65535, 0, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_LOAD, 15, -8388608, 8388607, 0, 0, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_COUNT, 0, 0, 0, 0, 20, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_PLACE, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.typed = 1;
    row.cmd = mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0);
    row.res = mk_res(7680, 7680, 7680, 7680, 0, 0, 0);
    rows.push_back(row);
    row.typed = 0;
    row.res = none;
    row.cmd = mk(ACT_PLACE, 0, 300 * 256, 300 * 256, 0, 0, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_TICK, 0, 305 * 256, 302 * 256, 0, 0, 1, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_TICK, 0, 500 * 256, 500 * 256, 0, 0, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_TICK, 0, 500 * 256, 500 * 256, 0, 0, 1, 1);
    rows.push_back(row);
    row.cmd = mk(ACT_COUNT, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_PLACE, 0, 8388607, -8388608, 0, 0, 0, 0);
    rows.push_back(row);
    row.cmd = mk(ACT_TICK, 0, -8388608, 8388607, 0, 0, 0, 1);
    rows.push_back(row);
    foreach (rows[i]) send_beat(rows[i].cmd, rows[i].typed, rows[i].res);

    // random part in four register settings
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = src_tab[ph];
      dst_idle = dst_tab[ph];
      if (ph == 1) begin
        wait_idle();
        write_reg(CFG_GRAVITY, 0);
        write_reg(CFG_FRICTION, 65535);
        write_reg(CFG_BOUNCE, 65535);
        write_reg(CFG_MINSPEED, 0);
        write_reg(CFG_WIDTH, 16'hffff);
        write_reg(CFG_HEIGHT, 8191);
        write_reg(CFG_RADIUS, 65535);
      end else if (ph == 2) begin
        wait_idle();
        write_reg(CFG_GRAVITY, 65535);
        write_reg(CFG_FRICTION, 0);
        write_reg(CFG_BOUNCE, 0);
        write_reg(CFG_MINSPEED, 65535);
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 1);
        write_reg(CFG_RADIUS, 0);
      end else if (ph == 3) begin
        wait_idle();
        write_reg(CFG_GRAVITY, $urandom_range(0, 512));
        write_reg(CFG_FRICTION, $urandom_range(60000, 65535));
        write_reg(CFG_BOUNCE, $urandom_range(0, 65535));
        write_reg(CFG_MINSPEED, $urandom_range(0, 100));
        write_reg(CFG_WIDTH, $urandom_range(200, 3000));
        write_reg(CFG_HEIGHT, $urandom_range(200, 3000));
        write_reg(CFG_RADIUS, $urandom_range(0, 20000));
      end
      for (int n = 0; n < 140; n++) begin
        if (ph == 0 && n == 30) stall_req = 1;
        send_beat(random_cmd(), 0, none);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_balls.size() != 0) @(negedge clk_i);
    repeat (2200) @(negedge clk_i);

    $display("covered %0d ticks (%0d dragging, %0d circle pushes) and %0d load beats,",
             n_ticks, n_drag, n_hits, n_other);
    $display("%0d result beats checked over four register settings", n_results);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
